@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro places one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// Shared types for the JSON string unescape unit.
// Result status codes and the result group passed from decoder to output stage.
`default_nettype none

package jsu_pkg;

  localparam int unsigned MaxResults = 4;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_CLOSED = 3'd1,
    ST_CTRL   = 3'd2,
    ST_ESC    = 3'd3,
    ST_HEX    = 3'd4,
    ST_PAIR   = 3'd5,
    ST_LONE   = 3'd6,
    ST_UNTERM = 3'd7
  } status_e;

  // All results caused by one input byte; bytes[0] leaves first.
  typedef struct packed {
    logic [2:0]                  count;
    status_e                     status;
    logic [MaxResults-1:0][7:0]  bytes;
  } group_t;

endpackage

`default_nettype wire

@@ rtl/jsu_decode.sv @@
// Escape decoder: holds the decode state and turns one byte into a result group.
// Depends on jsu_pkg for status codes and the group type.
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_input_i,
  output group_t          grp_o
);

  typedef enum logic [5:0] {
    M_NORMAL  = 6'b000001,
    M_ESC     = 6'b000010,
    M_HEX1    = 6'b000100,
    M_PAIR_BS = 6'b001000,
    M_PAIR_U  = 6'b010000,
    M_HEX2    = 6'b100000
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;

  // {valid, value}
  function automatic logic [4:0] nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  mode_e       mode_q, mode_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic [4:0]  nib;
  logic [15:0] acc_full;
  logic        err, closed, enc_en, lit_en;
  status_e     err_st;
  logic [20:0] cp;
  logic [7:0]  lit;

  assign nib      = nibble(in_byte_i);
  assign acc_full = {acc_q, nib[3:0]};

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    hs_d   = hs_q;
    err    = 1'b0;
    err_st = ST_BYTE;
    closed = 1'b0;
    enc_en = 1'b0;
    lit_en = 1'b0;
    lit    = 8'd0;
    cp     = 21'd0;

    unique case (mode_q) inside
      M_ESC: begin
        mode_d = M_NORMAL;
        lit_en = 1'b1;
        unique case (in_byte_i) inside
          ChQuote, ChBack, ChSlash: lit = in_byte_i;
          ChB: lit = 8'h08;
          ChF: lit = 8'h0C;
          ChN: lit = 8'h0A;
          ChR: lit = 8'h0D;
          ChT: lit = 8'h09;
          ChU: begin
            lit_en = 1'b0;
            mode_d = M_HEX1;
            acc_d  = 12'd0;
            cnt_d  = 2'd0;
          end
          default: begin
            lit_en = 1'b0;
            err    = 1'b1;
            err_st = ST_ESC;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (end_of_input_i && cnt_q != 2'd3) begin
          err    = 1'b1;
          err_st = ST_UNTERM;
        end else if (!nib[4]) begin
          err    = 1'b1;
          err_st = ST_HEX;
        end else if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
          acc_d = acc_full[11:0];
        end else begin
          cnt_d = 2'd0;
          acc_d = 12'd0;
          if (mode_q == M_HEX1) begin
            if (acc_full[15:10] == 6'b110110) begin
              hs_d   = acc_full[9:0];
              mode_d = M_PAIR_BS;
            end else if (acc_full[15:10] == 6'b110111) begin
              err    = 1'b1;
              err_st = ST_LONE;
            end else begin
              mode_d = M_NORMAL;
              enc_en = 1'b1;
              cp     = {5'd0, acc_full};
            end
          end else begin
            if (acc_full[15:10] != 6'b110111) begin
              err    = 1'b1;
              err_st = ST_PAIR;
            end else begin
              mode_d = M_NORMAL;
              enc_en = 1'b1;
              hs_d   = 10'd0;
              cp     = 21'h10000 + {1'b0, hs_q, acc_full[9:0]};
            end
          end
        end
      end
      M_PAIR_BS: begin
        if (end_of_input_i || in_byte_i != ChBack) begin
          err    = 1'b1;
          err_st = ST_PAIR;
        end else begin
          mode_d = M_PAIR_U;
        end
      end
      M_PAIR_U: begin
        if (in_byte_i != ChU) begin
          err    = 1'b1;
          err_st = ST_PAIR;
        end else begin
          mode_d = M_HEX2;
          acc_d  = 12'd0;
          cnt_d  = 2'd0;
        end
      end
      default: begin
        mode_d = M_NORMAL;
        if (in_byte_i == ChQuote) begin
          closed = 1'b1;
        end else if (in_byte_i == ChBack) begin
          mode_d = M_ESC;
        end else if (in_byte_i < ChSpace) begin
          err    = 1'b1;
          err_st = ST_CTRL;
        end else begin
          lit_en = 1'b1;
          lit    = in_byte_i;
        end
      end
    endcase

    // End of input voids whatever this byte decoded, unless the byte closed the string.
    if (!err && !closed && end_of_input_i) begin
      err    = 1'b1;
      err_st = (mode_d == M_PAIR_BS || mode_d == M_PAIR_U) ? ST_PAIR : ST_UNTERM;
    end

    if (err || closed) begin
      mode_d = M_NORMAL;
      acc_d  = 12'd0;
      cnt_d  = 2'd0;
      hs_d   = 10'd0;
    end
  end

  always_comb begin
    grp_o        = '0;
    grp_o.status = ST_BYTE;
    if (err) begin
      grp_o.count  = 3'd1;
      grp_o.status = err_st;
    end else if (closed) begin
      grp_o.count  = 3'd1;
      grp_o.status = ST_CLOSED;
    end else if (enc_en) begin
      if (cp <= 21'h7F) begin
        grp_o.count    = 3'd1;
        grp_o.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
        grp_o.count    = 3'd2;
        grp_o.bytes[0] = {3'b110, cp[10:6]};
        grp_o.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
        grp_o.count    = 3'd3;
        grp_o.bytes[0] = {4'b1110, cp[15:12]};
        grp_o.bytes[1] = {2'b10, cp[11:6]};
        grp_o.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        grp_o.count    = 3'd4;
        grp_o.bytes[0] = {5'b11110, cp[20:18]};
        grp_o.bytes[1] = {2'b10, cp[17:12]};
        grp_o.bytes[2] = {2'b10, cp[11:6]};
        grp_o.bytes[3] = {2'b10, cp[5:0]};
      end
    end else if (lit_en) begin
      grp_o.count    = 3'd1;
      grp_o.bytes[0] = lit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      acc_q  <= 12'd0;
      cnt_q  <= 2'd0;
      hs_q   <= 10'd0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      hs_q   <= hs_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jsu_out_ser.sv @@
// Result register: holds one result group and hands it out one transfer per cycle while out_stall_i is low.
// Depends on jsu_pkg for the group type.
`default_nettype none

module jsu_out_ser import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  group_t          grp_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            run_last_o
);

  logic                        valid_q;
  logic [1:0]                  rem_q;
  status_e                     status_q;
  logic [MaxResults-1:0][7:0]  bytes_q;
  logic                        take, last;

  assign take    = valid_q && !out_stall_i;
  assign last    = (rem_q == 2'd0);
  assign ready_o = !valid_q || (take && last);

  assign out_valid_o = valid_q;
  assign out_byte_o  = bytes_q[0];
  assign status_o    = status_q;
  assign run_last_o  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      rem_q   <= 2'(grp_i.count - 3'd1);
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        rem_q <= rem_q - 2'd1;
      end
    end
  end

  // Shift the next byte of the group into the head slot.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= grp_i.bytes;
      status_q <= grp_i.status;
    end else if (take) begin
      bytes_q <= {8'd0, bytes_q[MaxResults-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/json_string_unescape_utf8_unit.sv @@
// JSON string body unescaper with UTF-8 output.
// Input channel: in_byte_i / end_of_input_i with in_valid_i, in_stall_o; one byte of the
// string body per transfer, starting after the opening quote.
// Output channel: out_byte_o / status_o / run_last_o with out_valid_o, out_stall_i; each
// input byte gives zero to four results, run_last_o marks the final one of that byte.
// Status 0 carries a decoded byte; any other status (closed or an error) is a single
// result with out_byte_o zero, after which decoding restarts on a fresh string body.
// A byte is registered into the input register at its transfer, decoded from there into
// the result register, and its first result is presented from the result register.
// Throughput: one input byte per cycle while each byte yields at most one result and
// out_stall_i is low; a byte that decodes to a multi-byte UTF-8 sequence holds the result
// register until its last byte has left, which limits the rate for multi-byte code points.
// When the receiver stalls, the result holds and the input register fills, after which
// in_stall_o rises. Reset empties both registers and returns the decoder to the start of
// a string body.
// Depends on jsu_pkg, jsu_decode and jsu_out_ser.
`default_nettype none

module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            run_last_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  group_t     grp;
  logic       ser_ready, fire, load, accept;

  // A byte with no results advances without waiting on the result register.
  assign fire       = s1_valid_q && ((grp.count == 3'd0) || ser_ready);
  assign load       = fire && (grp.count != 3'd0);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_byte_i;
      s1_end_q  <= end_of_input_i;
    end
  end

  jsu_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .in_byte_i      (s1_byte_q),
    .end_of_input_i (s1_end_q),
    .grp_o          (grp)
  );

  jsu_out_ser u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .grp_i       (grp),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

@@ rtl/jsu_checker.sv @@
// Port-level checks for the JSON string unescape unit, bound to the top level.
// Depends on assert_macros.svh and jsu_pkg.
`default_nettype none

`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       end_of_input_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic [2:0] status_o,
  input wire logic       run_last_o
);

  // A stalled result holds until its transfer.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(run_last_o), "stalled result changed")

  // Closed and error results stand alone.
  `ASSERT_IMPL(a_status_last, clk_i, rst_ni, out_valid_o && status_o != ST_BYTE, run_last_o && out_byte_o == 8'd0, "non-byte result not alone or nonzero")

  // Once a multi-byte code point starts leaving, its remaining bytes stay valid without a gap.
  `ASSERT_NEXT(a_burst_cont, clk_i, rst_ni, out_valid_o && !out_stall_i && !run_last_o, out_valid_o && status_o == ST_BYTE, "UTF-8 sequence broken")

  // Continuation bytes of a sequence carry the 10xxxxxx marker.
  `ASSERT_NEXT(a_cont_marker, clk_i, rst_ni, out_valid_o && !out_stall_i && !run_last_o, out_byte_o[7:6] == 2'b10, "bad continuation byte")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_byte_i      (in_byte_i),
  .end_of_input_i (end_of_input_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .status_o       (status_o),
  .run_last_o     (run_last_o)
);

`default_nettype wire

@@ tb/jsu_tb_pkg.sv @@
`timescale 1ns / 100ps
// Result tracking for the JSON string unescape unit: byte-level decode prediction and
// an in-order store of expected results. Depends on jsu_pkg for the status codes.
package jsu_tb_pkg;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  localparam int MaxShown = 10;

  typedef enum logic [3:0] {
    DM_NORMAL,
    DM_ESC,
    DM_HEX_HIGH,
    DM_PAIR_BS,
    DM_PAIR_U,
    DM_HEX_LOW
  } dec_mode_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  function automatic int digit_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  class unescape_board;
    dec_mode_e   mode;
    logic [15:0] hex_acc;
    logic [1:0]  digits;
    logic [9:0]  high_bits;
    result_t     step_q[$];
    result_t     decoded_fifo[$];
    int          mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      mode      = DM_NORMAL;
      hex_acc   = '0;
      digits    = '0;
      high_bits = '0;
    endfunction

    function void put_byte(logic [7:0] d);
      result_t r;
      r.data   = d;
      r.status = ST_BYTE;
      r.last   = 1'b0;
      step_q   = {step_q, r};
    endfunction

    // Work out every result that one accepted byte causes and queue them in order.
    function void note_byte(logic [7:0] b, logic eoi);
      result_t     r;
      status_e     err;
      logic        terminal;
      logic        emit_cp;
      logic [20:0] cp;
      int          nib;
      step_q.delete();
      terminal = 1'b0;
      emit_cp  = 1'b0;
      err      = ST_BYTE;
      cp       = '0;
      nib      = digit_of(b);
      case (mode)
        DM_ESC: begin
          mode = DM_NORMAL;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: put_byte(b);
            CH_B: put_byte(8'h08);
            CH_F: put_byte(8'h0C);
            CH_N: put_byte(8'h0A);
            CH_R: put_byte(8'h0D);
            CH_T: put_byte(8'h09);
            CH_U: begin
              mode    = DM_HEX_HIGH;
              hex_acc = '0;
              digits  = '0;
            end
            default: begin
              terminal = 1'b1;
              err      = ST_ESC;
            end
          endcase
        end
        DM_HEX_HIGH, DM_HEX_LOW: begin
          // end of input inside the group wins over a bad digit
          if (eoi && digits != 2'd3) begin
            terminal = 1'b1;
            err      = ST_UNTERM;
          end else if (nib < 0) begin
            terminal = 1'b1;
            err      = ST_HEX;
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (digits != 2'd3) begin
              digits = digits + 2'd1;
            end else begin
              digits  = '0;
              cp      = {5'd0, hex_acc};
              hex_acc = '0;
              if (mode == DM_HEX_HIGH && cp >= HIGH_FIRST && cp <= HIGH_LAST) begin
                high_bits = cp[9:0];
                mode      = DM_PAIR_BS;
              end else if (mode == DM_HEX_HIGH && cp >= LOW_FIRST && cp <= LOW_LAST) begin
                terminal = 1'b1;
                err      = ST_LONE;
              end else if (mode == DM_HEX_LOW && (cp < LOW_FIRST || cp > LOW_LAST)) begin
                terminal = 1'b1;
                err      = ST_PAIR;
              end else begin
                if (mode == DM_HEX_LOW) begin
                  cp        = 21'h10000 + {1'b0, high_bits, cp[9:0]};
                  high_bits = '0;
                end
                mode    = DM_NORMAL;
                emit_cp = !eoi;
              end
            end
          end
        end
        DM_PAIR_BS: begin
          if (eoi || b != CH_BSLASH) begin
            terminal = 1'b1;
            err      = ST_PAIR;
          end else begin
            mode = DM_PAIR_U;
          end
        end
        DM_PAIR_U: begin
          if (b != CH_U) begin
            terminal = 1'b1;
            err      = ST_PAIR;
          end else begin
            mode    = DM_HEX_LOW;
            hex_acc = '0;
            digits  = '0;
          end
        end
        default: begin
          mode = DM_NORMAL;
          if (b == CH_QUOTE) begin
            terminal = 1'b1;
            err      = ST_CLOSED;
          end else if (b == CH_BSLASH) begin
            mode = DM_ESC;
          end else if (b < CH_SPACE) begin
            terminal = 1'b1;
            err      = ST_CTRL;
          end else begin
            put_byte(b);
          end
        end
      endcase

      if (emit_cp) begin
        if (cp <= 21'h7F) begin
          put_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
          put_byte({3'b110, cp[10:6]});
          put_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
          put_byte({4'b1110, cp[15:12]});
          put_byte({2'b10, cp[11:6]});
          put_byte({2'b10, cp[5:0]});
        end else begin
          put_byte({5'b11110, cp[20:18]});
          put_byte({2'b10, cp[17:12]});
          put_byte({2'b10, cp[11:6]});
          put_byte({2'b10, cp[5:0]});
        end
      end

      // drop decoded bytes when the string ends void
      if (!terminal && eoi) begin
        terminal = 1'b1;
        if (mode == DM_PAIR_BS || mode == DM_PAIR_U) err = ST_PAIR;
        else err = ST_UNTERM;
      end
      if (terminal) begin
        restart();
        step_q.delete();
        r.data   = 8'h00;
        r.status = err;
        r.last   = 1'b1;
        step_q   = {step_q, r};
      end else if (step_q.size() != 0) begin
        step_q[step_q.size() - 1].last = 1'b1;
      end
      decoded_fifo = {decoded_fifo, step_q};
    endfunction

    function void check_output(logic [7:0] d, logic [2:0] s, logic last);
      result_t want;
      logic    ok;
      string   why;
      if (decoded_fifo.size() == 0) begin
        want = '0;
        ok   = 1'b0;
        why  = "unexpected result";
      end else begin
        want = decoded_fifo.pop_front();
        ok   = (d === want.data) && (s === want.status) && (last === want.last);
        why  = "mismatch";
      end
      if (!ok) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("%0t %s: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
                   $time, why, want.data, want.status, want.last, d, s, last);
      end
    endfunction
  endclass

endpackage

@@ tb/tb_json_string_unescape_utf8_unit.sv @@
`timescale 1ns / 100ps
// Top-level testbench for json_string_unescape_utf8_unit: directed and random string
// bodies under varying idle and stall pressure. Depends on jsu_pkg and jsu_tb_pkg.
module tb_json_string_unescape_utf8_unit;
  import jsu_pkg::*;
  import jsu_tb_pkg::*;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte      = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       run_last;

  unescape_board board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int end_pct        = 0;
  int sent           = 0;

  json_string_unescape_utf8_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .status_o       (status),
    .run_last_o     (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each output transfer and pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      board.check_output(out_byte, status, run_last);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic pick_end();
    return $urandom_range(99) < end_pct;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_byte(b, eoi);
    sent++;
  endtask

  task automatic send_esc(input logic [7:0] c);
    send_byte(CH_BSLASH, pick_end());
    send_byte(c, pick_end());
  endtask

  task automatic send_u(input logic [15:0] v);
    send_esc(CH_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]), pick_end());
  endtask

  task automatic send_token();
    int          pick;
    logic [15:0] v;
    logic [7:0]  c;
    logic        known;
    pick = $urandom_range(99);
    if (pick < 35) begin
      do c = $urandom_range(8'h20, 8'hFF); while (c == CH_QUOTE || c == CH_BSLASH);
      send_byte(c, pick_end());
    end else if (pick < 50) begin
      case ($urandom_range(7))
        0: send_esc(CH_QUOTE);
        1: send_esc(CH_BSLASH);
        2: send_esc(CH_SLASH);
        3: send_esc(CH_B);
        4: send_esc(CH_F);
        5: send_esc(CH_N);
        6: send_esc(CH_R);
        default: send_esc(CH_T);
      endcase
    end else if (pick < 62) begin
      case ($urandom_range(2))
        0: v = $urandom_range(16'h7F);
        1: v = $urandom_range(16'h80, 16'h7FF);
        default: do v = $urandom_range(16'h800, 16'hFFFF);
                 while (v >= HIGH_FIRST && v <= LOW_LAST);
      endcase
      send_u(v);
    end else if (pick < 72) begin
      send_u($urandom_range(HIGH_FIRST, HIGH_LAST));
      send_u($urandom_range(LOW_FIRST, LOW_LAST));
    end else if (pick < 78) begin
      send_byte(CH_QUOTE, pick_end());
    end else if (pick < 84) begin
      send_byte($urandom_range(255), pick_end());
    end else begin
      // broken sequences
      case ($urandom_range(6))
        0: send_byte($urandom_range(8'h1F), pick_end());
        1: begin
          do begin
            c     = $urandom_range(255);
            known = 1'b0;
            case (c)
              CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: known = 1'b1;
              default: known = 1'b0;
            endcase
          end while (known);
          send_esc(c);
        end
        2: begin
          send_esc(CH_U);
          repeat ($urandom_range(3)) send_byte(hex_char($urandom_range(15)), pick_end());
          do c = $urandom_range(255); while (digit_of(c) >= 0);
          send_byte(c, pick_end());
        end
        3: send_u($urandom_range(LOW_FIRST, LOW_LAST));
        4: begin
          send_u($urandom_range(HIGH_FIRST, HIGH_LAST));
          do c = $urandom_range(255); while (c == CH_BSLASH);
          send_byte(c, pick_end());
        end
        5: begin
          send_u($urandom_range(HIGH_FIRST, HIGH_LAST));
          send_byte(CH_BSLASH, pick_end());
          do c = $urandom_range(255); while (c == CH_U);
          send_byte(c, pick_end());
        end
        default: begin
          send_u($urandom_range(HIGH_FIRST, HIGH_LAST));
          do v = $urandom_range(16'hFFFF); while (v >= LOW_FIRST && v <= LOW_LAST);
          send_u(v);
        end
      endcase
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: plain extremes, close, two- and four-byte code points, errors
    send_byte(8'h20, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_u(16'h00E9);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_esc(8'h71);
    send_u(16'hD83D);
    send_u(16'hDE00);
    send_esc(CH_U);
    send_byte(8'h67, 1'b0);
    send_byte(8'h61, 1'b1);

    end_pct = 4;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      while (sent < 80 * (phase + 1)) send_token();
    end
    in_valid       <= 1'b0;
    recv_stall_pct = 0;

    while (board.decoded_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.decoded_fifo.size() == 0) begin
      $display("** json_string_unescape_utf8_unit: PASSED **");
    end else begin
      $display("** json_string_unescape_utf8_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** json_string_unescape_utf8_unit: FAILED **");
    $finish;
  end

endmodule
